// ----- design/cpvp_pkg.sv -----
// ----------------------------------------------------------------------------
// cpvp_pkg
// Shared types, constants and helpers for the cascaded position/velocity PID.
// ----------------------------------------------------------------------------
package cpvp_pkg;

  localparam int DATA_W    = 32;               // Q16.16 word
  localparam int FRAC_W    = 16;
  localparam int MUL_W     = DATA_W + 1;       // room for unsigned dt
  localparam int PROD_W    = 2 * MUL_W;
  localparam int ACC_W     = PROD_W - FRAC_W;  // floored product / sum width
  localparam int DIV_STEPS = DATA_W + FRAC_W;  // quotient bits
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W = 3;

  typedef logic signed [DATA_W-1:0] q16_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  localparam acc_t SAT_HI      = acc_t'(64'sd2147483647);
  localparam acc_t SAT_LO      = acc_t'(-64'sd2147483648);
  localparam acc_t INTEG_LIMIT = acc_t'(64'sd655360);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_POSITION = 3'd0,
    REG_OUTER_P_GAIN    = 3'd1,
    REG_OUTER_I_GAIN    = 3'd2,
    REG_OUTER_D_GAIN    = 3'd3,
    REG_INNER_P_GAIN    = 3'd4,
    REG_INNER_I_GAIN    = 3'd5,
    REG_INNER_D_GAIN    = 3'd6
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_DIVGO,
    ST_INTEG,
    ST_PTERM,
    ST_ITERM,
    ST_DWAIT,
    ST_DMUL,
    ST_DTERM,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                  start;
    logic [DIV_STEPS-1:0]  num;
    logic [DATA_W-1:0]     den;
  } div_req_t;

  typedef struct packed {
    logic                  done;
    logic [DIV_STEPS-1:0]  quo;
  } div_stat_t;

  function automatic q16_t sat32(input acc_t v);
    q16_t r;
    if (v > SAT_HI) begin
      r = {1'b0, {(DATA_W-1){1'b1}}};
    end else if (v < SAT_LO) begin
      r = {1'b1, {(DATA_W-1){1'b0}}};
    end else begin
      r = v[DATA_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/cpvp_ifs.sv -----
// ----------------------------------------------------------------------------
// cpvp_in_if / cpvp_out_if
// Valid/ready channels for sample words and drive words.
// ----------------------------------------------------------------------------
interface cpvp_in_if import cpvp_pkg::*;;
  logic              valid;
  logic              ready;
  q16_t              position_sample;
  q16_t              velocity_sample;
  logic [DATA_W-1:0] timestamp;

  modport source (output valid, position_sample, velocity_sample, timestamp,
                  input ready);
  modport sink   (input valid, position_sample, velocity_sample, timestamp,
                  output ready);
endinterface

interface cpvp_out_if import cpvp_pkg::*;;
  logic valid;
  logic ready;
  q16_t drive;
  logic stepped;

  modport source (output valid, drive, stepped, input ready);
  modport sink   (input valid, drive, stepped, output ready);
endinterface

// ----- design/cpvp_mul.sv -----
// ----------------------------------------------------------------------------
// cpvp_mul
// Shared signed 33x33 multiplier with registered product.
// ----------------------------------------------------------------------------
module cpvp_mul import cpvp_pkg::*; (
  input  logic                     clk,
  input  logic signed [MUL_W-1:0]  a,
  input  logic signed [MUL_W-1:0]  b,
  output logic signed [PROD_W-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= a * b;
  end

endmodule

// ----- design/cpvp_div.sv -----
// ----------------------------------------------------------------------------
// cpvp_div
// Radix-2 restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module cpvp_div import cpvp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  div_req_t  req,
  output div_stat_t stat
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DATA_W-1:0]    rem_r, rem_nxt;
  logic [DIV_STEPS-1:0] work_r, work_nxt;
  logic [DATA_W-1:0]    den_r, den_nxt;

  logic [DATA_W:0]      trial;
  logic [DATA_W:0]      trial_sub;
  logic                 ge;

  assign trial     = {rem_r, work_r[DIV_STEPS-1]};
  assign ge        = trial >= {1'b0, den_r};
  assign trial_sub = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    work_nxt = work_r;
    den_nxt  = den_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      work_nxt = req.num;
      den_nxt  = req.den;
    end else if (busy_r) begin
      rem_nxt  = ge ? trial_sub[DATA_W-1:0] : trial[DATA_W-1:0];
      work_nxt = {work_r[DIV_STEPS-2:0], ge};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    work_r <= work_nxt;
    den_r  <= den_nxt;
  end

  assign stat.done = done_r;
  assign stat.quo  = work_r;

endmodule

// ----- design/cascaded_position_velocity_pid_top.sv -----
// ----------------------------------------------------------------------------
// cascaded_position_velocity_pid_top
// Cascaded position/velocity PID controller, signed Q16.16, sequenced over
// one shared multiplier and one bit-serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : sample word (position, velocity, timestamp), valid/ready.
//   out_ch : drive word (drive, stepped), valid/ready, one per sample word.
//   cfg_*  : write-only register port; index 0 target position, 1..3 outer
//            P/I/D gains, 4..6 inner P/I/D gains. Write only while idle.
//   A word that steps the loops runs the outer then the inner PID stage.
//   Each stage is dominated by the 48-step divider computing the
//   derivative; the multiplier work overlaps the division. A stepped
//   word reaches ST_OUT after both stages, a first or non-advancing
//   word straight from ST_IDLE; out_ch.valid rises from ST_OUT once the
//   output register is free. One word is in flight at a time: in_ch.ready
//   is high only in ST_IDLE, so no new word is taken before ST_OUT ends.
//   The result sits in an output register, so a stalled receiver holds the
//   drive word there while the next sample word is taken and worked on;
//   the sequencer only waits when it has a new result and the register is
//   still full.
//   Reset (rst_n low, synchronous) clears state, config, loop history and
//   integrators; the first sample after reset only records its timestamp.
// ----------------------------------------------------------------------------
module cascaded_position_velocity_pid_top import cpvp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  cpvp_in_if.sink              in_ch,
  cpvp_out_if.source           out_ch,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DATA_W-1:0]    cfg_wr_data
);

  // configuration registers
  q16_t target_r, okp_r, oki_r, okd_r, ikp_r, iki_r, ikd_r;

  // sequencer and loop history
  state_t            state_r, state_nxt;
  logic              stage_r, stage_nxt;        // 0 outer, 1 inner
  logic              seen_r, seen_nxt;
  logic [DATA_W-1:0] prev_time_r, prev_time_nxt;
  q16_t              prev_err_r [2];
  q16_t              integ_r    [2];
  q16_t              prev_err_nxt, integ_wr;
  logic              hist_we;

  // working registers
  q16_t              pos_r, pos_nxt;
  q16_t              vel_r, vel_nxt;
  logic [DATA_W-1:0] dt_r, dt_nxt;
  q16_t              err_r, err_nxt;
  q16_t              integ_new_r, integ_new_nxt;
  q16_t              deriv_r, deriv_nxt;
  q16_t              vset_r, vset_nxt;
  acc_t              acc_r, acc_nxt;
  logic              div_neg_r, div_neg_nxt;
  q16_t              res_drive_r, res_drive_nxt;
  logic              res_step_r, res_step_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  q16_t out_drive_r, out_drive_nxt;
  logic out_step_r, out_step_nxt;

  // shared units
  logic signed [MUL_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0] prod_r;
  div_req_t                 div_req;
  div_stat_t                div_stat;

  cpvp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (prod_r)
  );

  cpvp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .stat  (div_stat)
  );

  // per-stage operand selection
  q16_t              kp, ki, kd, err_a, err_b, prev_err_cur, integ_cur;
  acc_t              term, err_wide, integ_sum;
  logic signed [DATA_W:0] err_diff;
  logic [DATA_W:0]   diff_mag;
  logic              in_acc, out_free;

  assign kp           = stage_r ? ikp_r : okp_r;
  assign ki           = stage_r ? iki_r : oki_r;
  assign kd           = stage_r ? ikd_r : okd_r;
  assign err_a        = stage_r ? vset_r : target_r;
  assign err_b        = stage_r ? vel_r : pos_r;
  assign prev_err_cur = prev_err_r[stage_r];
  assign integ_cur    = integ_r[stage_r];

  // floor(product / 2^16) is the arithmetic shift
  assign term      = prod_r[PROD_W-1:FRAC_W];
  assign err_wide  = acc_t'(err_a) - acc_t'(err_b);
  assign integ_sum = acc_t'(integ_cur) + term;
  assign err_diff  = (DATA_W+1)'(err_r) - (DATA_W+1)'(prev_err_cur);
  assign diff_mag  = err_diff[DATA_W] ? (DATA_W+1)'(-err_diff) : err_diff;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  always_comb begin
    state_nxt     = state_r;
    stage_nxt     = stage_r;
    seen_nxt      = seen_r;
    prev_time_nxt = prev_time_r;
    pos_nxt       = pos_r;
    vel_nxt       = vel_r;
    dt_nxt        = dt_r;
    err_nxt       = err_r;
    integ_new_nxt = integ_new_r;
    deriv_nxt     = deriv_r;
    vset_nxt      = vset_r;
    acc_nxt       = acc_r;
    div_neg_nxt   = div_neg_r;
    res_drive_nxt = res_drive_r;
    res_step_nxt  = res_step_r;
    prev_err_nxt  = err_r;
    integ_wr      = integ_new_r;
    hist_we       = 1'b0;
    out_valid_nxt = out_valid_r;
    out_drive_nxt = out_drive_r;
    out_step_nxt  = out_step_r;
    mul_a         = '0;
    mul_b         = '0;
    div_req.start = 1'b0;
    div_req.num   = {diff_mag[DATA_W-1:0], {FRAC_W{1'b0}}};
    div_req.den   = dt_r;

    // receiver took the held word
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          pos_nxt       = in_ch.position_sample;
          vel_nxt       = in_ch.velocity_sample;
          dt_nxt        = in_ch.timestamp - prev_time_r;
          seen_nxt      = 1'b1;
          prev_time_nxt = in_ch.timestamp;
          stage_nxt     = 1'b0;
          if (seen_r && (in_ch.timestamp > prev_time_r)) begin
            state_nxt = ST_ERR;
          end else begin
            res_drive_nxt = '0;
            res_step_nxt  = 1'b0;
            state_nxt     = ST_OUT;
          end
        end
      end
      ST_ERR: begin
        err_nxt   = sat32(err_wide);
        state_nxt = ST_DIVGO;
      end
      ST_DIVGO: begin
        // derivative division runs while the multiplier does the rest
        div_req.start = 1'b1;
        div_neg_nxt   = err_diff[DATA_W];
        mul_a         = {1'b0, dt_r};
        mul_b         = MUL_W'(err_r);
        state_nxt     = ST_INTEG;
      end
      ST_INTEG: begin
        if (integ_sum > INTEG_LIMIT) begin
          integ_new_nxt = INTEG_LIMIT[DATA_W-1:0];
        end else if (integ_sum < -INTEG_LIMIT) begin
          integ_new_nxt = q16_t'(-INTEG_LIMIT);
        end else begin
          integ_new_nxt = integ_sum[DATA_W-1:0];
        end
        mul_a     = MUL_W'(err_r);
        mul_b     = MUL_W'(kp);
        state_nxt = ST_PTERM;
      end
      ST_PTERM: begin
        acc_nxt   = term;
        mul_a     = MUL_W'(integ_new_r);
        mul_b     = MUL_W'(ki);
        state_nxt = ST_ITERM;
      end
      ST_ITERM: begin
        acc_nxt   = acc_r + term;
        state_nxt = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_stat.done) begin
          if (!div_neg_r) begin
            if (div_stat.quo > DIV_STEPS'(SAT_HI)) begin
              deriv_nxt = SAT_HI[DATA_W-1:0];
            end else begin
              deriv_nxt = div_stat.quo[DATA_W-1:0];
            end
          end else begin
            if (div_stat.quo > DIV_STEPS'(-SAT_LO)) begin
              deriv_nxt = SAT_LO[DATA_W-1:0];
            end else begin
              deriv_nxt = -div_stat.quo[DATA_W-1:0];
            end
          end
          state_nxt = ST_DMUL;
        end
      end
      ST_DMUL: begin
        mul_a     = MUL_W'(deriv_r);
        mul_b     = MUL_W'(kd);
        state_nxt = ST_DTERM;
      end
      ST_DTERM: begin
        acc_nxt   = acc_r + term;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        hist_we = 1'b1;
        if (!stage_r) begin
          vset_nxt  = sat32(acc_r);
          stage_nxt = 1'b1;
          state_nxt = ST_ERR;
        end else begin
          res_drive_nxt = sat32(acc_r);
          res_step_nxt  = 1'b1;
          state_nxt     = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_drive_nxt = res_drive_r;
          out_step_nxt  = res_step_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state and loop history
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      stage_r     <= 1'b0;
      seen_r      <= 1'b0;
      prev_time_r <= '0;
      prev_err_r  <= '{default: '0};
      integ_r     <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stage_r     <= stage_nxt;
      seen_r      <= seen_nxt;
      prev_time_r <= prev_time_nxt;
      out_valid_r <= out_valid_nxt;
      if (hist_we) begin
        prev_err_r[stage_r] <= prev_err_nxt;
        integ_r[stage_r]    <= integ_wr;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= '0;
      okp_r    <= '0;
      oki_r    <= '0;
      okd_r    <= '0;
      ikp_r    <= '0;
      iki_r    <= '0;
      ikd_r    <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TARGET_POSITION: target_r <= cfg_wr_data;
        REG_OUTER_P_GAIN:    okp_r    <= cfg_wr_data;
        REG_OUTER_I_GAIN:    oki_r    <= cfg_wr_data;
        REG_OUTER_D_GAIN:    okd_r    <= cfg_wr_data;
        REG_INNER_P_GAIN:    ikp_r    <= cfg_wr_data;
        REG_INNER_I_GAIN:    iki_r    <= cfg_wr_data;
        REG_INNER_D_GAIN:    ikd_r    <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    pos_r       <= pos_nxt;
    vel_r       <= vel_nxt;
    dt_r        <= dt_nxt;
    err_r       <= err_nxt;
    integ_new_r <= integ_new_nxt;
    deriv_r     <= deriv_nxt;
    vset_r      <= vset_nxt;
    acc_r       <= acc_nxt;
    div_neg_r   <= div_neg_nxt;
    res_drive_r <= res_drive_nxt;
    res_step_r  <= res_step_nxt;
    out_drive_r <= out_drive_nxt;
    out_step_r  <= out_step_nxt;
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.drive   = out_drive_r;
  assign out_ch.stepped = out_step_r;

endmodule

// ----- design/cpvp_chk.sv -----
// ----------------------------------------------------------------------------
// cpvp_chk
// Port-level checks for the cascaded PID, bound to the top level.
// ----------------------------------------------------------------------------
module cpvp_chk import cpvp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input q16_t out_drive,
  input logic out_stepped
);

  // a held drive word does not change or vanish
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive) && $stable(out_stepped))
    else $error("drive word changed while stalled");

  // no step means zero drive
  a_zero_drive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stepped |-> out_drive == '0)
    else $error("nonzero drive without a step");

  // one sample word in flight: busy right after an accept
  a_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("sample word accepted while busy");

  // reset empties the output register
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("drive word valid after reset");

endmodule

bind cascaded_position_velocity_pid_top cpvp_chk u_cpvp_chk (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_drive   (out_ch.drive),
  .out_stepped (out_ch.stepped)
);
